FILE: sv/tst_pkg.sv
package tst_pkg;

    // Table geometry and limits.
    localparam int SLOTS       = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RES     = 16;
    localparam int NREP_W      = $clog2(MAX_RES + 1);

    localparam int CNT_W       = 32;
    localparam int TO_W        = 16;
    localparam int ENT_W       = CNT_W + TO_W;

    localparam logic [TO_W-1:0]  MAX_TIMEOUT = TO_W'(32768);
    localparam logic [CNT_W-1:0] MAX_DIFF    = CNT_W'(MAX_TIMEOUT);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        EV_STARTED = 2'd0,
        EV_REFUSED = 2'd1,
        EV_EXPIRED = 2'd2
    } t_event;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_INC    = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_CHECK  = 8'b0000_1000,
        S_RELOAD = 8'b0001_0000,
        S_FIND   = 8'b0010_0000,
        S_START  = 8'b0100_0000,
        S_FLUSH  = 8'b1000_0000
    } t_state;

    // Control of the shared adder.
    typedef struct packed {
        logic sub;
    } t_alu_ctl;

    // Reported slot number: the low four bits of the slot index.
    function automatic logic [3:0] slot_id_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+3:0] wide;
        wide = (IDX_W + 4)'(idx);
        return wide[3:0];
    endfunction

endpackage

FILE: sv/timer_slot_table.sv
// Timer slot table: SLOTS timers driven by a 32-bit tick count that advances
// by one on each tick request. A clear request is done in the idle state and
// gives no result. A start request walks the slot valid bits one per cycle
// looking for the lowest free slot. A tick request advances the count, then
// reads and checks each slot in turn, with a reload step for each expiring
// periodic slot, and last hands over the final result. The pace is set by
// the single read port of the slot memory and by the one shared 32-bit adder
// that forms the tick count, the wrapped difference and the new deadlines.
// Results leave through a one-entry output register; a tick holds one
// expiry back so that the final one can be flagged with o_last. The block
// does not take a new request until the current one has finished.
module timer_slot_table
    import tst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_timeout,
    input  logic [15:0] i_period,
    input  logic [3:0]  i_slot,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_res,
    output logic [3:0]  o_slot_id,
    output logic        o_last
);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [NREP_W-1:0]   r_nrep, n_nrep;
    logic [SLOTS-1:0]    r_active, n_active;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_pend_valid, n_pend_valid;
    logic                r_out_valid, n_out_valid;

    logic [TO_W-1:0]     r_to, n_to;
    logic [TO_W-1:0]     r_per, n_per;
    t_event              r_pend_ev, n_pend_ev;
    logic [3:0]          r_pend_id, n_pend_id;
    t_event              r_out_ev, n_out_ev;
    logic [3:0]          r_out_id, n_out_id;
    logic                r_out_last, n_out_last;

    t_alu_ctl            alu_ctl;
    logic [CNT_W-1:0]    alu_b;
    logic [CNT_W-1:0]    alu_res;
    logic                alu_le_max;

    logic                ram_we;
    logic                ram_re;
    logic [ENT_W-1:0]    ram_wdata;
    logic [ENT_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]    rd_deadline;
    logic [TO_W-1:0]     rd_reload;

    logic                out_free;
    logic                expire;
    logic                report;
    logic                stall;

    assign rd_deadline = ram_rdata[ENT_W-1:TO_W];
    assign rd_reload   = ram_rdata[TO_W-1:0];

    tst_ram #(
        .WIDTH(ENT_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_idx),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    tst_alu u_alu (
        .i_ctl   (alu_ctl),
        .i_a     (r_count),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_le_max(alu_le_max)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_event_res = r_out_ev;
    assign o_slot_id   = r_out_id;
    assign o_last      = r_out_last;

    assign out_free = !r_out_valid || i_ready;
    assign expire   = r_active[r_idx] && alu_le_max;
    assign report   = expire && (r_nrep < NREP_W'(MAX_RES));
    // A new expiry can only be taken once the held one has somewhere to go.
    assign stall    = report && r_pend_valid && !out_free;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_nrep       = r_nrep;
        n_active     = r_active;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid;
        n_to         = r_to;
        n_per        = r_per;
        n_pend_ev    = r_pend_ev;
        n_pend_id    = r_pend_id;
        n_out_ev     = r_out_ev;
        n_out_id     = r_out_id;
        n_out_last   = r_out_last;

        alu_ctl.sub  = 1'b0;
        alu_b        = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = {alu_res, r_per};

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_operation)
                        OP_TICK: begin
                            n_state = S_INC;
                        end
                        OP_START: begin
                            n_to    = (i_timeout > MAX_TIMEOUT) ? MAX_TIMEOUT : i_timeout;
                            n_per   = i_period;
                            n_idx   = '0;
                            n_state = S_FIND;
                        end
                        OP_CLEAR: begin
                            if (32'(i_slot) < 32'(SLOTS)) begin
                                n_active[IDX_W'(i_slot)] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INC: begin
                alu_b   = CNT_W'(1);
                n_count = alu_res;
                n_idx   = '0;
                n_nrep  = '0;
                n_state = S_READ;
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                alu_ctl.sub = 1'b1;
                alu_b       = rd_deadline;
                if (!stall) begin
                    if (report) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_ev    = r_pend_ev;
                            n_out_id    = r_pend_id;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_ev    = EV_EXPIRED;
                        n_pend_id    = slot_id_of(r_idx);
                        n_nrep       = r_nrep + NREP_W'(1);
                    end
                    if (expire && (rd_reload != '0)) begin
                        n_state = S_RELOAD;
                    end else begin
                        if (expire) begin
                            n_active[r_idx] = 1'b0;
                        end
                        if (r_idx == LAST_IDX) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx   = r_idx + IDX_W'(1);
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_RELOAD: begin
                alu_b     = CNT_W'(rd_reload);
                ram_we    = 1'b1;
                ram_wdata = {alu_res, rd_reload};
                if (r_idx == LAST_IDX) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_READ;
                end
            end
            S_FIND: begin
                if (!r_active[r_idx]) begin
                    n_state = S_START;
                end else if (r_idx == LAST_IDX) begin
                    n_pend_valid = 1'b1;
                    n_pend_ev    = EV_REFUSED;
                    n_pend_id    = '0;
                    n_state      = S_FLUSH;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_START: begin
                alu_b           = CNT_W'(r_to);
                ram_we          = 1'b1;
                ram_wdata       = {alu_res, r_per};
                n_active[r_idx] = 1'b1;
                n_pend_valid    = 1'b1;
                n_pend_ev       = EV_STARTED;
                n_pend_id       = slot_id_of(r_idx);
                n_state         = S_FLUSH;
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_ev     = r_pend_ev;
                    n_out_id     = r_pend_id;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_nrep       <= '0;
            r_active     <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_nrep       <= n_nrep;
            r_active     <= n_active;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_to       <= n_to;
        r_per      <= n_per;
        r_pend_ev  <= n_pend_ev;
        r_pend_id  <= n_pend_id;
        r_out_ev   <= n_out_ev;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    // Nothing may be held back once the block is ready for a new request.
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_pend_valid)
        else $error("held result left behind at end of request");

    // A result without the final flag always has a successor waiting.
    a_not_last_has_successor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> r_pend_valid)
        else $error("non-final result with no successor");

    // The number of expiries reported on one tick never exceeds the limit.
    a_report_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nrep <= NREP_W'(MAX_RES))
        else $error("expiry report count above limit");

    // A started timer occupies its slot in the following cycle.
    a_start_marks_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |=> r_active[$past(r_idx)])
        else $error("started slot not marked active");

    // An accepted tick request first advances the tick count.
    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_operation == OP_TICK)) |=> (r_state == S_INC))
        else $error("tick request did not advance the count");

endmodule

FILE: sv/tst_ram.sv
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tst_alu.sv
module tst_alu
    import tst_pkg::*;
(
    input  t_alu_ctl          i_ctl,
    input  logic [CNT_W-1:0]  i_a,
    input  logic [CNT_W-1:0]  i_b,
    output logic [CNT_W-1:0]  o_res,
    output logic              o_le_max
);

    // One 32-bit adder serves the increment, the wrapped difference and the
    // deadline sums.
    assign o_res    = i_ctl.sub ? (i_a - i_b) : (i_a + i_b);
    assign o_le_max = (o_res <= MAX_DIFF);

endmodule

FILE: dv/tst_event_check.sv
`timescale 1ns / 100ps

module tst_event_check
    import tst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_timeout,
    input  logic [15:0] i_period,
    input  logic [3:0]  i_slot,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_event_res,
    input  logic [3:0]  i_slot_id,
    input  logic        i_last,
    output int          o_pending,
    output int          o_fail_count
);

    typedef struct packed {
        t_event     ev;
        logic [3:0] slot_id;
        logic       last;
    } timer_event_t;

    logic             slot_busy     [SLOTS];
    logic [CNT_W-1:0] slot_deadline [SLOTS];
    logic [TO_W-1:0]  slot_reload   [SLOTS];
    logic [CNT_W-1:0] tick_cnt;
    timer_event_t     pending_events [$];
    timer_event_t     oldest;
    int               pending_cnt = 0;
    int               fail_cnt    = 0;

    assign o_pending    = pending_cnt;
    assign o_fail_count = fail_cnt;

    // Applies one request to the shadow slot table and queues the events it raises.
    task automatic advance_table(input logic [1:0] op, input logic [15:0] to,
                                 input logic [15:0] per, input logic [3:0] sl);
        logic [TO_W-1:0] sat_to;
        logic [3:0]      fired [MAX_RES];
        int              n_fired;
        int              free_idx;
        timer_event_t    ev_item;
        n_fired  = 0;
        free_idx = -1;
        case (op)
            OP_TICK: begin
                tick_cnt = tick_cnt + 1'b1;
                for (int i = 0; i < SLOTS; i++) begin
                    // Wrapped difference: a deadline still ahead gives a huge value.
                    if (slot_busy[i] && (tick_cnt - slot_deadline[i]) <= MAX_DIFF) begin
                        if (n_fired < MAX_RES) begin
                            fired[n_fired] = 4'(i);
                            n_fired++;
                        end
                        if (slot_reload[i] != '0) begin
                            slot_deadline[i] = tick_cnt + CNT_W'(slot_reload[i]);
                        end else begin
                            slot_busy[i] = 1'b0;
                        end
                    end
                end
                for (int k = 0; k < n_fired; k++) begin
                    ev_item.ev      = EV_EXPIRED;
                    ev_item.slot_id = fired[k];
                    ev_item.last    = (k == n_fired - 1);
                    pending_events.push_back(ev_item);
                end
            end
            OP_START: begin
                sat_to = (to > MAX_TIMEOUT) ? MAX_TIMEOUT : to;
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_busy[i]) begin
                        free_idx = i;
                    end
                end
                ev_item.last = 1'b1;
                if (free_idx >= 0) begin
                    slot_busy[free_idx]     = 1'b1;
                    slot_deadline[free_idx] = tick_cnt + CNT_W'(sat_to);
                    slot_reload[free_idx]   = per;
                    ev_item.ev      = EV_STARTED;
                    ev_item.slot_id = 4'(free_idx);
                end else begin
                    ev_item.ev      = EV_REFUSED;
                    ev_item.slot_id = 4'd0;
                end
                pending_events.push_back(ev_item);
            end
            OP_CLEAR: begin
                if (int'(sl) < SLOTS) begin
                    slot_busy[sl] = 1'b0;
                end
            end
            default: begin
                // The spare operation code leaves the table untouched.
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_busy[i]) slot_busy[i] = 1'b0;
            tick_cnt = '0;
            pending_events.delete();
        end else begin
            // Results are taken first, so that a request accepted on the same
            // edge cannot be matched against its own events.
            if (i_res_valid && i_res_ready) begin
                if (pending_events.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: expected no result, got event %0d slot %0d last %0d",
                             $time, i_event_res, i_slot_id, i_last);
                end else begin
                    oldest = pending_events.pop_front();
                    if (i_event_res !== oldest.ev || i_slot_id !== oldest.slot_id ||
                        i_last !== oldest.last) begin
                        fail_cnt++;
                        $display("%0t: expected event %0d slot %0d last %0d, %s %0d %0d %0d",
                                 $time, oldest.ev, oldest.slot_id, oldest.last,
                                 "got event/slot/last", i_event_res, i_slot_id, i_last);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                advance_table(i_operation, i_timeout, i_period, i_slot);
            end
        end
        pending_cnt = pending_events.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tst_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 225;
    localparam int QUIET_FROM   = 190;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [15:0] i_timeout;
    logic [15:0] i_period;
    logic [3:0]  i_slot;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_event_res;
    logic [3:0]  o_slot_id;
    logic        o_last;

    int   pending;
    int   fail_count;
    logic no_idle = 1'b0;
    int   ready_hold = 0;
    logic ready_stall = 1'b0;
    int   stall_cycles = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    timer_slot_table dut (.*);

    tst_event_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_operation  (i_operation),
        .i_timeout    (i_timeout),
        .i_period     (i_period),
        .i_slot       (i_slot),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_event_res  (o_event_res),
        .i_slot_id    (o_slot_id),
        .i_last       (o_last),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [1:0] op, input logic [15:0] to,
                                input logic [15:0] per, input logic [3:0] sl);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_timeout   <= to;
        i_period    <= per;
        i_slot      <= sl;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_for_events;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Result side: random runs of readiness and stalls, none near the end.
    always @(negedge i_clk) begin
        if (no_idle) begin
            i_ready <= 1'b1;
        end else begin
            if (ready_hold == 0) begin
                ready_stall = ($urandom_range(0, 2) == 0);
                ready_hold  = ready_stall ? $urandom_range(1, 12) : $urandom_range(1, 40);
            end
            ready_hold--;
            i_ready <= !ready_stall;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timer_slot_table: mismatch");
            $finish;
        end
    end

    initial begin
        int          done;
        int          pick;
        int          idle_pct;
        logic [1:0]  op;
        logic [15:0] to;
        logic [15:0] per;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_TICK;
        i_timeout   = '0;
        i_period    = '0;
        i_slot      = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: an empty tick, the spare code, saturation, then a
        // full table, a refused start and a tick on which every slot expires.
        send_request(OP_TICK, 16'hFFFF, 16'hFFFF, 4'hF);
        send_request(OP_UNUSED, 16'($urandom), 16'($urandom), 4'($urandom));
        send_request(OP_START, 16'd0, 16'd0, 4'd0);
        send_request(OP_START, 16'hFFFF, 16'hFFFF, 4'hF);
        send_request(OP_START, 16'd1, 16'd1, 4'd0);
        send_request(OP_TICK, 16'd0, 16'd0, 4'd0);
        send_request(OP_CLEAR, 16'd0, 16'd0, 4'd1);
        send_request(OP_CLEAR, 16'hFFFF, 16'hFFFF, 4'd1);
        repeat (15) send_request(OP_START, 16'd0, 16'd0, 4'($urandom));
        send_request(OP_START, 16'($urandom), 16'($urandom), 4'($urandom));
        send_request(OP_TICK, 16'($urandom), 16'($urandom), 4'($urandom));
        wait_for_events();

        done     = 0;
        idle_pct = 25;
        while (done < RANDOM_ITEMS) begin
            if (done % 30 == 0) begin
                idle_pct = 25 * $urandom_range(0, 2);
            end
            if (done >= QUIET_FROM) begin
                no_idle <= 1'b1;
            end else begin
                if ($urandom_range(0, 99) < idle_pct) begin
                    idle_cycles($urandom_range(1, 12));
                end
                if ($urandom_range(0, 49) == 0) begin
                    wait_for_events();
                end
            end

            // Short timeouts keep expiries frequent; the odd long one parks a slot.
            case ($urandom_range(0, 19))
                0:       to = 16'($urandom);
                1:       to = MAX_TIMEOUT + 16'($urandom_range(0, 2)) - 16'd1;
                default: to = 16'($urandom_range(0, 10));
            endcase
            case ($urandom_range(0, 9))
                0:             per = 16'($urandom);
                1, 2, 3, 4:    per = 16'd0;
                default:       per = 16'($urandom_range(1, 6));
            endcase

            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_request(OP_UNUSED, to, per, 4'($urandom));
            end else begin
                if (pick < 42) begin
                    op = OP_TICK;
                end else if (pick < 80) begin
                    op = OP_START;
                end else begin
                    op = OP_CLEAR;
                end
                send_request(op, to, per, 4'($urandom));
                done++;
            end
        end

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("timer_slot_table: match");
        end else begin
            $display("timer_slot_table: mismatch");
        end
        $finish;
    end

endmodule
